>>> design/u8u16_pkg.sv
// Package: shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned ValueW = 21;

  // Lead byte masks and match patterns
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContCode   = 8'h80;

  localparam logic [ValueW-1:0] SuppBase  = 21'h10000;
  localparam logic [UnitW-1:0]  HighBase  = 16'hD800;
  localparam logic [UnitW-1:0]  LowBase   = 16'hDC00;

  // Sequence assembly state
  typedef struct packed {
    logic [1:0]        pending;
    logic [ValueW-1:0] partial;
    logic              bad;
  } dec_state_t;

  // One result beat
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             run_end;
    logic             text_end;
  } unit_t;

  // Up to two result beats caused by one byte
  typedef struct packed {
    logic  first_vld;
    unit_t first;
    logic  second_vld;
    unit_t second;
  } dec_out_t;

endpackage

`default_nettype wire

>>> design/u8u16_if.sv
// Interfaces: byte input channel and code unit result channel.
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        run_end;
  logic        text_end;

  modport source (output valid, output code_unit, output unit_valid,
                  output run_end, output text_end, input ready);
  modport sink   (input valid, input code_unit, input unit_valid,
                  input run_end, input text_end, output ready);
endinterface

`default_nettype wire

>>> design/u8u16_decode.sv
// Decoder: next sequence state and result beats for one UTF-8 byte.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode
  import u8u16_pkg::*;
(
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             last_i,
  input  wire dec_state_t       state_i,
  output dec_state_t            state_o,
  output dec_out_t              res_o
);

  logic              have_value;
  logic [ValueW-1:0] value;
  logic [ValueW-1:0] supp;
  dec_state_t        upd;

  always_comb begin
    upd        = state_i;
    have_value = 1'b0;
    value      = '0;
    if (state_i.pending == 2'd0) begin
      if (byte_i[7] == 1'b0) begin
        have_value = 1'b1;
        value      = {{(ValueW-ByteW){1'b0}}, byte_i};
      end else if ((byte_i & Lead2Mask) == Lead2Code) begin
        upd.partial = {{(ValueW-5){1'b0}}, byte_i[4:0]};
        upd.pending = 2'd1;
        upd.bad     = 1'b0;
      end else if ((byte_i & Lead3Mask) == Lead3Code) begin
        upd.partial = {{(ValueW-4){1'b0}}, byte_i[3:0]};
        upd.pending = 2'd2;
        upd.bad     = 1'b0;
      end else if ((byte_i & Lead4Mask) == Lead4Code) begin
        upd.partial = {{(ValueW-3){1'b0}}, byte_i[2:0]};
        upd.pending = 2'd3;
        upd.bad     = 1'b0;
      end
    end else begin
      if ((byte_i & ContMask) != ContCode) begin
        upd.bad = 1'b1;
      end
      upd.partial = {state_i.partial[ValueW-7:0], byte_i[5:0]};
      upd.pending = state_i.pending - 2'd1;
      if (upd.pending == 2'd0 && !upd.bad) begin
        have_value = 1'b1;
        value      = upd.partial;
      end
    end
  end

  assign supp = value - SuppBase;

  always_comb begin
    res_o = '0;
    if (have_value) begin
      res_o.first_vld = 1'b1;
      if (value < SuppBase) begin
        res_o.first.code_unit  = value[UnitW-1:0];
        res_o.first.unit_valid = 1'b1;
        res_o.first.run_end    = 1'b1;
        res_o.first.text_end   = last_i;
      end else begin
        res_o.first.code_unit   = HighBase + {5'd0, supp[20:10]};
        res_o.first.unit_valid  = 1'b1;
        res_o.second_vld        = 1'b1;
        res_o.second.code_unit  = LowBase + {6'd0, supp[9:0]};
        res_o.second.unit_valid = 1'b1;
        res_o.second.run_end    = 1'b1;
        res_o.second.text_end   = last_i;
      end
    end else if (last_i) begin
      res_o.first_vld       = 1'b1;
      res_o.first.run_end   = 1'b1;
      res_o.first.text_end  = 1'b1;
    end
  end

  // Drop all sequence state at the end of the text
  assign state_o = last_i ? dec_state_t'('0) : upd;

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_transcoder_core.sv
// Top level: UTF-8 byte stream in, UTF-16 code unit beats out.
//
//   channel | dir | payload                                      | handshake
//   --------+-----+----------------------------------------------+------------
//   in_ch   | in  | in_byte[7:0], last_byte                      | valid/ready
//   out_ch  | out | code_unit[15:0], unit_valid, run_end, text_end | valid/ready
//
// A byte is decoded in the cycle it is accepted; its first result beat sits in
// the output register on the next cycle. One byte per cycle is sustained while
// the sink takes a beat per cycle; a 4-byte sequence ending in a surrogate pair
// holds a second beat in the pair register, which blocks input until it moves
// up. rst_n is synchronous, active low, and clears the sequence state and
// both beat valids. A stalled sink holds the output beat; input is taken
// alongside only when the current beat leaves in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder_core
  import u8u16_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  u8u16_in_if.sink       in_ch,
  u8u16_out_if.source    out_ch
);

  // Sequence state
  dec_state_t state_r, state_nxt, dec_state;
  dec_out_t   dec_res;

  // Output beat register and the held low surrogate
  logic  out_valid_r, out_valid_nxt;
  unit_t out_unit_r, out_unit_nxt;
  logic  pair_valid_r, pair_valid_nxt;
  unit_t pair_unit_r, pair_unit_nxt;

  logic in_ready;
  logic accept;
  logic out_fire;

  u8u16_decode u_decode (
    .byte_i  (in_ch.in_byte),
    .last_i  (in_ch.last_byte),
    .state_i (state_r),
    .state_o (dec_state),
    .res_o   (dec_res)
  );

  // Take a byte only when the pair register is empty and the output slot frees
  assign out_fire = out_valid_r && out_ch.ready;
  assign in_ready = !pair_valid_r && (!out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_unit_nxt   = out_unit_r;
    pair_valid_nxt = pair_valid_r;
    pair_unit_nxt  = pair_unit_r;
    if (accept) begin
      // Advance the sequence and load the new beats
      state_nxt      = dec_state;
      out_valid_nxt  = dec_res.first_vld;
      out_unit_nxt   = dec_res.first;
      pair_valid_nxt = dec_res.second_vld;
      pair_unit_nxt  = dec_res.second;
    end else if (out_fire) begin
      // Move the held low surrogate up, or empty the slot
      out_valid_nxt  = pair_valid_r;
      out_unit_nxt   = pair_unit_r;
      pair_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      pair_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pair_valid_r <= pair_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_unit_r  <= out_unit_nxt;
    pair_unit_r <= pair_unit_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_unit  = out_unit_r.code_unit;
  assign out_ch.unit_valid = out_unit_r.unit_valid;
  assign out_ch.run_end    = out_unit_r.run_end;
  assign out_ch.text_end   = out_unit_r.text_end;

endmodule

`default_nettype wire
